/* sv/awpp_pkg.sv */
package awpp_pkg;

  localparam int unsigned RAW_W      = 32;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SAMPLE_LSB = 16;
  localparam int unsigned IDX_W      = 14;
  localparam int unsigned WLEN_W     = 15;
  localparam int unsigned WLEN_RESET = 16000;
  localparam int unsigned CNT_W      = 32;
  // wide enough for any index or length up to the largest window depth
  localparam int unsigned EXT_W      = 17;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_RELEASE = 2'd1,
    OP_READ    = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [SAMPLE_W-1:0] sample;
    logic [IDX_W-1:0]    idx;
    logic                idx_ok;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       pending;
    logic                       pend_bank;
    logic                       fill_bank;
    logic [IDX_W-1:0]           fill_pos;
    logic                       completed;
    logic [CNT_W-1:0]           overrun;
  } res_t;

endpackage

/* sv/awpp_ram.sv */
module awpp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/awpp_fifo.sv */
module awpp_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH-1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH-1)) ? '0 : rd_ptr_q + PW'(1);
    end
    count_d = count_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* sv/awpp_front.sv */
module awpp_front #(
  parameter int unsigned WINDOW_DEPTH = 16384
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic [1:0]                        opcode_i,
  input  logic [awpp_pkg::RAW_W-1:0]        raw_word_i,
  input  logic [awpp_pkg::IDX_W-1:0]        read_index_i,
  output logic                              cmd_valid_o,
  output awpp_pkg::cmd_t                    cmd_o,
  input  logic                              cmd_pop_i
);

  localparam int unsigned CMD_DEPTH = 2;

  awpp_pkg::cmd_t                 cmd_in;
  awpp_pkg::cmd_t                 cmd_out;
  logic                           cmd_empty;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
  logic [awpp_pkg::EXT_W-1:0]     idx_ext;

  // classify the beat: opcode, sample slice, index range check
  always_comb begin
    idx_ext        = awpp_pkg::EXT_W'(read_index_i);
    cmd_in.op      = awpp_pkg::op_e'(opcode_i);
    cmd_in.sample  = raw_word_i[awpp_pkg::SAMPLE_LSB +: awpp_pkg::SAMPLE_W];
    cmd_in.idx     = read_index_i;
    cmd_in.idx_ok  = (idx_ext < awpp_pkg::EXT_W'(WINDOW_DEPTH));
  end

  awpp_fifo #(
    .WIDTH ($bits(awpp_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  assign cmd_valid_o = !cmd_empty && (cmd_count != '0);
  assign cmd_o       = cmd_out;

endmodule

/* sv/awpp_back.sv */
module awpp_back #(
  parameter int unsigned WINDOW_DEPTH = 16384
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [awpp_pkg::WLEN_W-1:0] cfg_wdata_i,
  input  logic                        cmd_valid_i,
  input  awpp_pkg::cmd_t              cmd_i,
  output logic                        cmd_pop_o,
  output logic                        res_empty_o,
  input  logic                        res_pop_i,
  output awpp_pkg::res_t              res_o
);

  localparam int unsigned AW        = $clog2(WINDOW_DEPTH);
  localparam int unsigned LW        = $clog2(WINDOW_DEPTH+1);
  localparam int unsigned RAM_DEPTH = 2 * (2**AW);
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RCW       = $clog2(RES_DEPTH+1);
  localparam int unsigned LEN_RESET =
    (awpp_pkg::WLEN_RESET > WINDOW_DEPTH) ? WINDOW_DEPTH : awpp_pkg::WLEN_RESET;

  logic [AW-1:0]              wpos_q, wpos_d;
  logic                       abank_q, abank_d;
  logic                       rbank_q, rbank_d;
  logic                       ready_q, ready_d;
  logic [awpp_pkg::CNT_W-1:0] overrun_q, overrun_d;
  logic [LW-1:0]              len_q, len_d;

  logic                       issue;
  logic [RCW:0]               used;
  logic [RCW-1:0]             res_count;
  logic                       res_full;
  logic                       completed;
  logic                       ram_we, ram_re;
  logic [AW:0]                ram_waddr, ram_raddr;
  logic [awpp_pkg::SAMPLE_W-1:0] ram_rdata;
  logic [LW-1:0]              pos_inc;
  logic                       wrap;
  logic [awpp_pkg::EXT_W-1:0] idx_ext, wpos_ext, cfg_ext;

  logic                       s2_valid_q;
  logic                       s2_rd_q;
  awpp_pkg::res_t             s2_res_q;
  awpp_pkg::res_t             res_in;

  // keep room in the result queue for everything already in flight
  assign used      = (RCW+1)'(res_count) + (RCW+1)'(s2_valid_q);
  assign issue     = cmd_valid_i && (used < (RCW+1)'(RES_DEPTH));
  assign cmd_pop_o = issue;

  assign pos_inc = LW'(wpos_q) + LW'(1);
  assign wrap    = (pos_inc >= len_q);
  assign idx_ext = awpp_pkg::EXT_W'(cmd_i.idx);

  always_comb begin
    cfg_ext = awpp_pkg::EXT_W'(cfg_wdata_i);
    len_d   = len_q;
    if (cfg_we_i) begin
      if (cfg_ext == '0) begin
        len_d = LW'(1);
      end else if (cfg_ext > awpp_pkg::EXT_W'(WINDOW_DEPTH)) begin
        len_d = LW'(WINDOW_DEPTH);
      end else begin
        len_d = cfg_ext[LW-1:0];
      end
    end
  end

  always_comb begin
    wpos_d    = wpos_q;
    abank_d   = abank_q;
    rbank_d   = rbank_q;
    ready_d   = ready_q;
    overrun_d = overrun_q;
    completed = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = {abank_q, wpos_q};
    ram_raddr = {rbank_q, idx_ext[AW-1:0]};
    if (issue) begin
      case (cmd_i.op)
        awpp_pkg::OP_PUSH: begin
          ram_we = 1'b1;
          if (wrap) begin
            completed = 1'b1;
            wpos_d    = '0;
            if (ready_q) begin
              // pending window untouched, the one just finished is dropped
              overrun_d = overrun_q + awpp_pkg::CNT_W'(1);
            end else begin
              rbank_d = abank_q;
              ready_d = 1'b1;
              abank_d = ~abank_q;
            end
          end else begin
            wpos_d = pos_inc[AW-1:0];
          end
        end
        awpp_pkg::OP_RELEASE: begin
          ready_d = 1'b0;
        end
        awpp_pkg::OP_READ: begin
          ram_re = ready_q && cmd_i.idx_ok;
        end
        awpp_pkg::OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign wpos_ext = awpp_pkg::EXT_W'(wpos_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q     <= '0;
      abank_q    <= 1'b0;
      rbank_q    <= 1'b0;
      ready_q    <= 1'b0;
      overrun_q  <= '0;
      len_q      <= LW'(LEN_RESET);
      s2_valid_q <= 1'b0;
      s2_rd_q    <= 1'b0;
    end else begin
      wpos_q     <= wpos_d;
      abank_q    <= abank_d;
      rbank_q    <= rbank_d;
      ready_q    <= ready_d;
      overrun_q  <= overrun_d;
      len_q      <= len_d;
      s2_valid_q <= issue;
      s2_rd_q    <= ram_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s2_res_q.sample    <= '0;
      s2_res_q.pending   <= ready_d;
      s2_res_q.pend_bank <= rbank_d;
      s2_res_q.fill_bank <= abank_d;
      s2_res_q.fill_pos  <= wpos_ext[awpp_pkg::IDX_W-1:0];
      s2_res_q.completed <= completed;
      s2_res_q.overrun   <= overrun_d;
    end
  end

  awpp_ram #(
    .WIDTH (awpp_pkg::SAMPLE_W),
    .DEPTH (RAM_DEPTH)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (cmd_i.sample),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    res_in        = s2_res_q;
    res_in.sample = s2_rd_q ? $signed(ram_rdata) : '0;
  end

  awpp_fifo #(
    .WIDTH ($bits(awpp_pkg::res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s2_valid_q),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (res_pop_i),
    .rdata_o (res_o),
    .empty_o (res_empty_o),
    .count_o (res_count)
  );

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> !res_full)
    else $error("result beat pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ready_q) |-> $past(issue && cmd_i.op == awpp_pkg::OP_PUSH && wrap))
    else $error("window marked ready without a completing push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (overrun_q != $past(overrun_q)) |-> ($past(ready_q) && ready_q))
    else $error("overrun counted with no window pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (abank_q != $past(abank_q)) |-> (ready_q && rbank_q == $past(abank_q)))
    else $error("filling bank switched without handing over the window");
`endif

endmodule

/* sv/audio_window_ping_pong_buffer.sv */
// throughput: one beat per cycle while the result queue has room; each beat
// makes at most one window ram access (a write for push, a read for read), with
// a two-entry command queue and a four-entry result queue so either side may
// stall on its own
// reset: control, positions, flags and counter clear at once; the window ram is
// not cleared and reads only windows already written
module audio_window_ping_pong_buffer #(
  parameter int unsigned WINDOW_DEPTH = 16384
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [1:0]                          opcode_i,
  input  logic [awpp_pkg::RAW_W-1:0]          raw_word_i,
  input  logic [awpp_pkg::IDX_W-1:0]          read_index_i,
  input  logic                                cfg_we_i,
  input  logic [awpp_pkg::WLEN_W-1:0]         cfg_wdata_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [awpp_pkg::SAMPLE_W-1:0] read_sample_o,
  output logic                                window_pending_o,
  output logic                                pending_bank_o,
  output logic                                filling_bank_o,
  output logic [awpp_pkg::IDX_W-1:0]          fill_position_o,
  output logic                                window_completed_o,
  output logic [awpp_pkg::CNT_W-1:0]          overrun_total_o
);

  awpp_pkg::cmd_t cmd;
  awpp_pkg::res_t res;
  logic           cmd_valid;
  logic           cmd_pop;

  awpp_front #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .opcode_i     (opcode_i),
    .raw_word_i   (raw_word_i),
    .read_index_i (read_index_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  awpp_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .res_o       (res)
  );

  assign read_sample_o      = res.sample;
  assign window_pending_o   = res.pending;
  assign pending_bank_o     = res.pend_bank;
  assign filling_bank_o     = res.fill_bank;
  assign fill_position_o    = res.fill_pos;
  assign window_completed_o = res.completed;
  assign overrun_total_o    = res.overrun;

endmodule

/* test/awpp_window_check.sv */
`timescale 1ns / 100ps

module awpp_window_check #(
  parameter int unsigned WINDOW_DEPTH = 16384
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 push,
  input  logic                                 full,
  input  logic [1:0]                           opcode_i,
  input  logic [awpp_pkg::RAW_W-1:0]           raw_word_i,
  input  logic [awpp_pkg::IDX_W-1:0]           read_index_i,
  input  logic                                 cfg_we_i,
  input  logic [awpp_pkg::WLEN_W-1:0]          cfg_wdata_i,
  input  logic                                 empty,
  input  logic                                 pop,
  input  logic signed [awpp_pkg::SAMPLE_W-1:0] read_sample_i,
  input  logic                                 window_pending_i,
  input  logic                                 pending_bank_i,
  input  logic                                 filling_bank_i,
  input  logic [awpp_pkg::IDX_W-1:0]           fill_position_i,
  input  logic                                 window_completed_i,
  input  logic [awpp_pkg::CNT_W-1:0]           overrun_total_i,
  output int                                   errors_o,
  output int                                   outstanding_o,
  output int                                   read_bound_o,
  output int                                   checked_o,
  output int                                   windows_o,
  output int                                   dropped_o,
  output int                                   ready_reads_o
);

  // predicted copy of the window store and its control state
  logic [awpp_pkg::SAMPLE_W-1:0] win_mem [2*WINDOW_DEPTH];
  int unsigned                   wr_pos;
  logic                          fill_bank;
  logic                          pend_bank;
  logic                          pend_flag;
  logic [awpp_pkg::CNT_W-1:0]    overruns;
  logic [awpp_pkg::WLEN_W-1:0]   win_len;
  // positions written from zero upwards in each bank, never shrinks
  int unsigned                   written_len [2];
  awpp_pkg::res_t                expected_q [$];
  awpp_pkg::res_t                want;
  awpp_pkg::res_t                got;

  task automatic step_window(input awpp_pkg::op_e op,
                             input logic [awpp_pkg::RAW_W-1:0] raw,
                             input logic [awpp_pkg::IDX_W-1:0] idx,
                             output awpp_pkg::res_t r);
    int unsigned eff;
    r   = '0;
    eff = (win_len == 0) ? 1 : ((win_len > WINDOW_DEPTH) ? WINDOW_DEPTH : win_len);
    case (op)
      awpp_pkg::OP_PUSH: begin
        if (wr_pos >= WINDOW_DEPTH) wr_pos = 0;
        win_mem[fill_bank * WINDOW_DEPTH + wr_pos] =
          raw[awpp_pkg::SAMPLE_LSB +: awpp_pkg::SAMPLE_W];
        if (wr_pos == written_len[fill_bank]) written_len[fill_bank]++;
        wr_pos++;
        if (wr_pos >= eff) begin
          wr_pos      = 0;
          r.completed = 1'b1;
          windows_o++;
          if (pend_flag) begin
            // the window just finished is dropped, the pending one stays intact
            overruns++;
            dropped_o++;
          end else begin
            pend_bank = fill_bank;
            pend_flag = 1'b1;
            fill_bank = ~fill_bank;
          end
        end
      end
      awpp_pkg::OP_RELEASE: pend_flag = 1'b0;
      awpp_pkg::OP_READ: begin
        if (pend_flag && idx < WINDOW_DEPTH) begin
          r.sample = win_mem[pend_bank * WINDOW_DEPTH + idx];
          ready_reads_o++;
        end
      end
      default: ;
    endcase
    r.pending   = pend_flag;
    r.pend_bank = pend_bank;
    r.fill_bank = fill_bank;
    r.fill_pos  = wr_pos[awpp_pkg::IDX_W-1:0];
    r.overrun   = overruns;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      errors_o++;
      if (errors_o <= 10)
        $display("mismatch in %s of result beat %0d: expected %0h, got %0h",
                 name, checked_o, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pos         = 0;
      fill_bank      = 1'b0;
      pend_bank      = 1'b0;
      pend_flag      = 1'b0;
      overruns       = '0;
      win_len        = awpp_pkg::WLEN_W'(awpp_pkg::WLEN_RESET);
      written_len[0] = 0;
      written_len[1] = 0;
      expected_q.delete();
      errors_o       = 0;
      checked_o      = 0;
      windows_o      = 0;
      dropped_o      = 0;
      ready_reads_o  = 0;
      outstanding_o <= 0;
      read_bound_o  <= 0;
    end else begin
      if (cfg_we_i) win_len = cfg_wdata_i;
      if (push && !full) begin
        step_window(awpp_pkg::op_e'(opcode_i), raw_word_i, read_index_i, want);
        expected_q.push_back(want);
      end
      if (pop && !empty) begin
        got.sample    = read_sample_i;
        got.pending   = window_pending_i;
        got.pend_bank = pending_bank_i;
        got.fill_bank = filling_bank_i;
        got.fill_pos  = fill_position_i;
        got.completed = window_completed_i;
        got.overrun   = overrun_total_i;
        if (expected_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("result beat %0d arrived with none expected", checked_o);
        end else begin
          want = expected_q.pop_front();
          check_field("read_sample", want.sample, got.sample);
          check_field("window_pending", want.pending, got.pending);
          check_field("pending_bank", want.pend_bank, got.pend_bank);
          check_field("filling_bank", want.fill_bank, got.fill_bank);
          check_field("fill_position", want.fill_pos, got.fill_pos);
          check_field("window_completed", want.completed, got.completed);
          check_field("overrun_total", want.overrun, got.overrun);
        end
        checked_o++;
      end
      outstanding_o <= expected_q.size();
      read_bound_o  <= (written_len[0] < written_len[1]) ? written_len[0] : written_len[1];
    end
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned WINDOW_DEPTH = 16384;
  localparam int          ITEMS        = 1500;
  localparam int          CALM_TAIL    = 250;
  localparam int          QUIET_LIMIT  = 2000;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni;
  logic                                 push;
  logic                                 full;
  logic [1:0]                           opcode_i;
  logic [awpp_pkg::RAW_W-1:0]           raw_word_i;
  logic [awpp_pkg::IDX_W-1:0]           read_index_i;
  logic                                 cfg_we_i;
  logic [awpp_pkg::WLEN_W-1:0]          cfg_wdata_i;
  logic                                 empty;
  logic                                 pop;
  logic signed [awpp_pkg::SAMPLE_W-1:0] read_sample_o;
  logic                                 window_pending_o;
  logic                                 pending_bank_o;
  logic                                 filling_bank_o;
  logic [awpp_pkg::IDX_W-1:0]           fill_position_o;
  logic                                 window_completed_o;
  logic [awpp_pkg::CNT_W-1:0]           overrun_total_o;

  int errors, outstanding, read_bound, checked, windows, dropped, ready_reads;
  int gap_pct, stall_pct, stall_left;
  int beats_sent, len_writes;

  always #4 clk_i = ~clk_i;

  audio_window_ping_pong_buffer #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .opcode_i          (opcode_i),
    .raw_word_i        (raw_word_i),
    .read_index_i      (read_index_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .empty             (empty),
    .pop               (pop),
    .read_sample_o     (read_sample_o),
    .window_pending_o  (window_pending_o),
    .pending_bank_o    (pending_bank_o),
    .filling_bank_o    (filling_bank_o),
    .fill_position_o   (fill_position_o),
    .window_completed_o(window_completed_o),
    .overrun_total_o   (overrun_total_o)
  );

  awpp_window_check #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_window_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .opcode_i          (opcode_i),
    .raw_word_i        (raw_word_i),
    .read_index_i      (read_index_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .empty             (empty),
    .pop               (pop),
    .read_sample_i     (read_sample_o),
    .window_pending_i  (window_pending_o),
    .pending_bank_i    (pending_bank_o),
    .filling_bank_i    (filling_bank_o),
    .fill_position_i   (fill_position_o),
    .window_completed_i(window_completed_o),
    .overrun_total_i   (overrun_total_o),
    .errors_o          (errors),
    .outstanding_o     (outstanding),
    .read_bound_o      (read_bound),
    .checked_o         (checked),
    .windows_o         (windows),
    .dropped_o         (dropped),
    .ready_reads_o     (ready_reads)
  );

  // result side: pop held low in random bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      pop <= 1'b0;
      stall_left = $urandom_range(0, 10);
    end else begin
      pop <= 1'b1;
    end
  end

  // push is left high after a beat so back-to-back beats need no second assignment
  task automatic send_beat(input awpp_pkg::op_e op, input logic [awpp_pkg::RAW_W-1:0] raw,
                           input logic [awpp_pkg::IDX_W-1:0] idx);
    if ($urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    push         <= 1'b1;
    opcode_i     <= op;
    raw_word_i   <= raw;
    read_index_i <= idx;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    beats_sent++;
  endtask

  // only written once every expected beat is back and the pipeline has settled
  task automatic set_window_length(input logic [awpp_pkg::WLEN_W-1:0] len);
    push <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    len_writes++;
  endtask

  task automatic read_ready(input logic [awpp_pkg::RAW_W-1:0] raw);
    // reads stay below the span written in both banks, so no unwritten entry is touched
    if (read_bound == 0) begin
      send_beat(awpp_pkg::OP_NOP, raw, awpp_pkg::IDX_W'($urandom()));
    end else begin
      send_beat(awpp_pkg::OP_READ, raw,
                awpp_pkg::IDX_W'($urandom_range(0, read_bound - 1)));
    end
  endtask

  task automatic random_beat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 62) begin
      send_beat(awpp_pkg::OP_PUSH, $urandom(), awpp_pkg::IDX_W'($urandom()));
    end else if (r < 82) begin
      read_ready($urandom());
    end else if (r < 88) begin
      send_beat(awpp_pkg::OP_RELEASE, $urandom(), awpp_pkg::IDX_W'($urandom()));
    end else if (r < 93) begin
      // consumer pattern: a few reads of the ready window, then hand it back
      repeat ($urandom_range(1, 4)) read_ready($urandom());
      send_beat(awpp_pkg::OP_RELEASE, $urandom(), awpp_pkg::IDX_W'($urandom()));
    end else begin
      send_beat(awpp_pkg::OP_NOP, $urandom(), awpp_pkg::IDX_W'($urandom()));
    end
  endtask

  function automatic logic [awpp_pkg::WLEN_W-1:0] pick_length(input int phase);
    int r;
    r = $urandom_range(0, 19);
    if (phase == 0) return awpp_pkg::WLEN_W'(WINDOW_DEPTH);
    if (phase == 1) return awpp_pkg::WLEN_W'(1);
    case (r)
      0:       return '0;
      1:       return awpp_pkg::WLEN_W'(WINDOW_DEPTH);
      2:       return '1;
      3:       return awpp_pkg::WLEN_W'(1);
      4:       return awpp_pkg::WLEN_W'(awpp_pkg::WLEN_RESET);
      default: return awpp_pkg::WLEN_W'($urandom_range(2, 12));
    endcase
  endfunction

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || cfg_we_i) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    int phase;
    int n;
    rst_ni       = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    opcode_i     = awpp_pkg::OP_NOP;
    raw_word_i   = '0;
    read_index_i = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    gap_pct      = 0;
    stall_pct    = 0;
    stall_left   = 0;
    beats_sent   = 0;
    len_writes   = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle commands, sample extremes, overrun and length corner cases
    gap_pct   = 20;
    stall_pct = 20;
    send_beat(awpp_pkg::OP_READ, 32'h0, '1);
    send_beat(awpp_pkg::OP_RELEASE, 32'h0, '0);
    send_beat(awpp_pkg::OP_NOP, '1, '1);
    send_beat(awpp_pkg::OP_PUSH, 32'hFFFF_FFFF, '0);
    send_beat(awpp_pkg::OP_PUSH, 32'h0000_0000, '0);
    send_beat(awpp_pkg::OP_PUSH, 32'h8000_0000, '0);
    send_beat(awpp_pkg::OP_PUSH, 32'h7FFF_FFFF, '0);
    // length dropped under the fill position: next push lands at 4 and closes the window
    set_window_length(awpp_pkg::WLEN_W'(3));
    send_beat(awpp_pkg::OP_PUSH, 32'h1234_5678, '0);
    send_beat(awpp_pkg::OP_READ, '0, '0);
    send_beat(awpp_pkg::OP_READ, '0, awpp_pkg::IDX_W'(4));
    repeat (3) send_beat(awpp_pkg::OP_PUSH, $urandom(), '0);
    send_beat(awpp_pkg::OP_RELEASE, '0, '0);
    repeat (3) send_beat(awpp_pkg::OP_PUSH, $urandom(), '0);
    send_beat(awpp_pkg::OP_READ, '0, awpp_pkg::IDX_W'(2));
    send_beat(awpp_pkg::OP_READ, '0, '0);
    send_beat(awpp_pkg::OP_RELEASE, '0, '0);
    // zero length behaves as one sample per window
    set_window_length('0);
    send_beat(awpp_pkg::OP_PUSH, $urandom(), '0);
    send_beat(awpp_pkg::OP_PUSH, $urandom(), '0);
    send_beat(awpp_pkg::OP_RELEASE, '0, '0);
    set_window_length('1);
    send_beat(awpp_pkg::OP_PUSH, $urandom(), '0);
    send_beat(awpp_pkg::OP_PUSH, $urandom(), '0);

    phase = 0;
    while (beats_sent < ITEMS) begin
      if (beats_sent >= ITEMS - CALM_TAIL) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
      end
      set_window_length(pick_length(phase));
      n = $urandom_range(20, 90);
      repeat (n) random_beat();
      phase++;
    end

    push <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (8) @(posedge clk_i);

    $display("%0d beats sent over %0d window length settings, %0d result beats checked",
             beats_sent, len_writes, checked);
    $display("%0d windows closed, %0d dropped while one was pending, %0d reads of a ready window",
             windows, dropped, ready_reads);
    if (errors == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
